// ----- design/rbs_pkg.sv -----
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared constants and register codes for the ray/box slab intersect block.
// ----------------------------------------------------------------------------
package rbs_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int DIST_WIDTH      = 31;
  localparam int CFG_IDX_WIDTH   = 3;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } rbs_reg_e;

endpackage

// ----- design/rbs_if.sv -----
// ----------------------------------------------------------------------------
// rbs_if
// Valid/ready channels: ray input, hit output, configuration write.
// ----------------------------------------------------------------------------
interface rbs_ray_if import rbs_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] origin_x;
  logic signed [COORD_WIDTH-1:0] origin_y;
  logic signed [COORD_WIDTH-1:0] origin_z;
  logic signed [COORD_WIDTH-1:0] direction_x;
  logic signed [COORD_WIDTH-1:0] direction_y;
  logic signed [COORD_WIDTH-1:0] direction_z;

  modport source (output valid, origin_x, origin_y, origin_z,
                  direction_x, direction_y, direction_z, input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z,
                  direction_x, direction_y, direction_z, output ready);
endinterface

interface rbs_hit_if import rbs_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [DIST_WIDTH-1:0] hit_distance;

  modport source (output valid, hit, hit_distance, input ready);
  modport sink   (input valid, hit, hit_distance, output ready);
endinterface

interface rbs_cfg_if import rbs_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_WIDTH-1:0] index;
  logic [COORD_WIDTH-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/ray_box_slab_intersect.sv -----
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Slab test of one ray against a configured axis-aligned box, pipelined.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  ray_i    | in  | origin_x/y/z, direction_x/y/z (signed fixed point)
//  hit_o    | out | hit, hit_distance
//  cfg_i    | in  | index (register 0..5), data
//
//  One ray per cycle while the output is not stalled; the bit-per-stage dividers
//  (six in parallel, COORD_WIDTH + 2 stages each) set the pipeline depth.
//  Reset clears the box registers to 0 and all valid bits.
//  A stalled output freezes the whole pipeline; ray_i.ready drops with it.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect import rbs_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rbs_cfg_if.sink  cfg_i,
  rbs_ray_if.sink  ray_i,
  rbs_hit_if.source hit_o
);

  localparam int W  = COORD_WIDTH;
  localparam int DL = W + 2;
  localparam logic signed [W-1:0] MaxRaw = {1'b0, {(W-1){1'b1}}};

  logic signed [W-1:0] box_min_q [3];
  logic signed [W-1:0] box_max_q [3];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        box_min_q[i] <= '0;
        box_max_q[i] <= '0;
      end
    end else if (cfg_i.valid) begin
      unique case (rbs_reg_e'(cfg_i.index))
        REG_BOX_MIN_X: box_min_q[0] <= cfg_i.data;
        REG_BOX_MIN_Y: box_min_q[1] <= cfg_i.data;
        REG_BOX_MIN_Z: box_min_q[2] <= cfg_i.data;
        REG_BOX_MAX_X: box_max_q[0] <= cfg_i.data;
        REG_BOX_MAX_Y: box_max_q[1] <= cfg_i.data;
        REG_BOX_MAX_Z: box_max_q[2] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  logic en;
  logic vo_q;
  assign en          = !vo_q || hit_o.ready;
  assign ray_i.ready = en;

  // stage 0: input register
  logic                v0_q;
  logic signed [W-1:0] org_q [3];
  logic signed [W-1:0] dir_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      org_q[0] <= ray_i.origin_x;
      org_q[1] <= ray_i.origin_y;
      org_q[2] <= ray_i.origin_z;
      dir_q[0] <= ray_i.direction_x;
      dir_q[1] <= ray_i.direction_y;
      dir_q[2] <= ray_i.direction_z;
    end
  end

  // stage 1: slab differences, parallel-axis checks
  logic                v1_q;
  logic [W:0]          mag1_q [6];
  logic                neg1_q [6];
  logic signed [W-1:0] dir1_q [3];
  logic [2:0]          zero1_q;
  logic [2:0]          pm1_q;

  logic signed [W:0] diff [6];
  logic [2:0]        zero_d;
  logic [2:0]        pm_d;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      diff[2*j]   = {box_min_q[j][W-1], box_min_q[j]} - {org_q[j][W-1], org_q[j]};
      diff[2*j+1] = {box_max_q[j][W-1], box_max_q[j]} - {org_q[j][W-1], org_q[j]};
      zero_d[j]   = dir_q[j] == '0;
      pm_d[j]     = zero_d[j] && ((org_q[j] < box_min_q[j]) || (box_max_q[j] < org_q[j]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < 6; s++) begin
        neg1_q[s] <= diff[s][W];
        mag1_q[s] <= diff[s][W] ? (W+1)'(-diff[s]) : (W+1)'(diff[s]);
      end
      for (int j = 0; j < 3; j++) begin
        dir1_q[j] <= dir_q[j];
      end
      zero1_q <= zero_d;
      pm1_q   <= pm_d;
    end
  end

  // dividers
  logic signed [W-1:0] quot [6];

  for (genvar s = 0; s < 6; s++) begin : g_div
    rbs_div #(.W(W), .F(FRAC_BITS)) u_div (
      .clk_i     (clk_i),
      .en_i      (en),
      .num_neg_i (neg1_q[s]),
      .num_mag_i (mag1_q[s]),
      .den_i     (dir1_q[s/2]),
      .quot_o    (quot[s])
    );
  end

  logic [DL-1:0] vd_q;
  logic [2:0]    zd_q [DL];
  logic [2:0]    pd_q [DL];

  always_ff @(posedge clk_i) begin
    if (en) begin
      zd_q[0] <= zero1_q;
      pd_q[0] <= pm1_q;
      for (int i = 1; i < DL; i++) begin
        zd_q[i] <= zd_q[i-1];
        pd_q[i] <= pd_q[i-1];
      end
    end
  end

  // stage: order slab distances per axis
  logic                v2_q;
  logic signed [W-1:0] lo_q [3];
  logic signed [W-1:0] hi_q [3];
  logic                pm2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        if (zd_q[DL-1][j]) begin
          lo_q[j] <= '0;
          hi_q[j] <= MaxRaw;
        end else if (quot[2*j+1] < quot[2*j]) begin
          lo_q[j] <= quot[2*j+1];
          hi_q[j] <= quot[2*j];
        end else begin
          lo_q[j] <= quot[2*j];
          hi_q[j] <= quot[2*j+1];
        end
      end
      pm2_q <= |pd_q[DL-1];
    end
  end

  // stage: near / far bounds
  logic                v3_q;
  logic signed [W-1:0] near_q;
  logic signed [W-1:0] far_q;
  logic                pm3_q;
  logic signed [W-1:0] near_d;
  logic signed [W-1:0] far_d;

  always_comb begin
    near_d = '0;
    far_d  = MaxRaw;
    for (int j = 0; j < 3; j++) begin
      if (near_d < lo_q[j]) near_d = lo_q[j];
      if (hi_q[j] < far_d)  far_d  = hi_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      near_q <= near_d;
      far_q  <= far_d;
      pm3_q  <= pm2_q;
    end
  end

  // output register
  logic                  hit_q;
  logic [DIST_WIDTH-1:0] dist_q;
  logic                  hit_d;
  logic [63:0]           near_ext;

  always_comb begin
    hit_d    = !pm3_q && !(far_q < near_q);
    near_ext = 64'(unsigned'(near_q));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= hit_d;
      if (!hit_d) begin
        dist_q <= '0;
      end else if (near_ext > 64'({DIST_WIDTH{1'b1}})) begin
        dist_q <= {DIST_WIDTH{1'b1}};
      end else begin
        dist_q <= near_ext[DIST_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      vd_q <= '0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v0_q <= ray_i.valid;
      v1_q <= v0_q;
      vd_q <= {vd_q[DL-2:0], v1_q};
      v2_q <= vd_q[DL-1];
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  assign hit_o.valid        = vo_q;
  assign hit_o.hit          = hit_q;
  assign hit_o.hit_distance = dist_q;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o.valid && !hit_o.hit |-> hit_o.hit_distance == '0)
    else $error("miss with nonzero distance");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vd_q) && $stable(v2_q) && $stable(v3_q))
    else $error("pipeline moved during stall");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ray_i.valid && ray_i.ready |=> v0_q)
    else $error("accepted ray not captured");

endmodule

// ----- design/rbs_div.sv -----
// ----------------------------------------------------------------------------
// rbs_div
// Pipelined fixed-point divider, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module rbs_div import rbs_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF,
  parameter int F = FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic                num_neg_i,
  input  logic [W:0]          num_mag_i,
  input  logic signed [W-1:0] den_i,
  output logic signed [W-1:0] quot_o
);

  localparam int NW = W + 1 + F;
  localparam int HW = F + 1;
  localparam int CW = (HW > W) ? HW : W;

  logic          den_neg;
  logic [W-1:0]  dm;
  logic [NW-1:0] num;
  logic [HW-1:0] hi;
  logic          ovf;

  logic [W-1:0] rem_q [W+1];
  logic [W-1:0] quo_q [W+1];
  logic [W-1:0] lo_q  [W];
  logic [W-1:0] dm_q  [W];
  logic         neg_q [W+1];
  logic         ovf_q [W+1];

  always_comb begin
    den_neg = den_i[W-1];
    dm      = den_neg ? W'(-den_i) : W'(den_i);
    num     = {num_mag_i, {F{1'b0}}};
    hi      = num[NW-1:W];
    ovf     = CW'(hi) >= CW'(dm);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= W'(hi);
      quo_q[0] <= '0;
      lo_q[0]  <= num[W-1:0];
      dm_q[0]  <= dm;
      neg_q[0] <= num_neg_i ^ den_neg;
      ovf_q[0] <= ovf;
    end
  end

  for (genvar s = 0; s < W; s++) begin : g_step
    logic [W-1:0] r2;
    logic         ge;
    assign r2 = {rem_q[s][W-2:0], lo_q[s][W-1]};
    assign ge = r2 >= dm_q[s];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= ge ? (r2 - dm_q[s]) : r2;
        quo_q[s+1] <= {quo_q[s][W-2:0], ge};
        neg_q[s+1] <= neg_q[s];
        ovf_q[s+1] <= ovf_q[s];
      end
    end
    if (s < W - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          lo_q[s+1] <= lo_q[s] << 1;
          dm_q[s+1] <= dm_q[s];
        end
      end
    end
  end

  logic         sat;
  logic [W-1:0] res;

  always_comb begin
    sat = ovf_q[W] | quo_q[W][W-1];
    if (neg_q[W]) begin
      res = sat ? {1'b1, {(W-1){1'b0}}} : W'(-quo_q[W]);
    end else begin
      res = sat ? {1'b0, {(W-1){1'b1}}} : quo_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_o <= res;
    end
  end

endmodule
